@@ rtl/core/bloom_guarded_dictionary_encoder_core_macros.svh @@
// Assertion macros for the checker file of the dictionary encoder core.
// No dependencies.
`ifndef BLOOM_GUARDED_DICTIONARY_ENCODER_CORE_MACROS_SVH
`define BLOOM_GUARDED_DICTIONARY_ENCODER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BGDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define BGDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bgde_pkg.sv @@
// Types, codes and constants of the dictionary encoder core.
// No dependencies; the files that use it refer to it by scoped names.
package bgde_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_BUILD  = 2'd2,
        CMD_ENCODE = 2'd3
    } cmd_e;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

    localparam logic REG_BITS_PER_ENTRY = 1'b0;
    localparam logic REG_HASH_COUNT     = 1'b1;

    localparam int          CFG_W     = 16;
    localparam logic [15:0] BPE_RESET = 16'd2560;
    localparam logic [4:0]  HC_RESET  = 5'd7;

    localparam logic [63:0] MIX_C1      = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2      = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam int          SIZE_FLOOR  = 64;

    typedef struct packed {
        cmd_e        command;
        logic [31:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        filter_positive;
        logic        exact_hit;
        logic [11:0] entry_index;
        logic [31:0] miss_word;
        logic [12:0] entry_count;
        logic [16:0] filter_size;
        logic [2:0]  index_bytes;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic clr_dict;
        logic unbuild;
        logic k_clear;
        logic k_inc;
        logic entry_write;
        logic set_found;
        logic set_full;
        logic set_not_built;
        logic size_calc;
        logic fclr_step;
        logic hash_start;
        logic hash_src_entry;
        logic probe_init;
        logic mod_start;
        logic filt_set;
        logic probe_next;
        logic set_ready;
        logic set_pos;
        logic out_load;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_e cmd;
        logic k_lt_count;
        logic found_eq;
        logic full;
        logic ready_ok;
        logic fclr_last;
        logic hash_done;
        logic mod_done;
        logic i_lt_hc;
        logic bit_set;
    } sts_t;

endpackage

@@ rtl/core/bloom_guarded_dictionary_encoder_core.sv @@
// Top level of the Bloom-guarded dictionary encoder core.
// Uses bgde_pkg, bgde_ctrl and bgde_datapath.
//
// The core takes one command at a time and gives one result for each. A clear
// goes from dispatch straight to its result. An add scans the dictionary,
// reading and then comparing each stored word, and appends the word when no
// match is found and the dictionary is not full. An encode that is not built
// reports the not-built status; otherwise it runs the 64-bit hash unit, then
// the remainder unit for each filter probe, and on a positive the same scan.
// A build first clears the filter RAM in a pass, one 64-bit word a cycle,
// then hashes each stored word and sets its bit at every probe position.
// A finished result sits in an output register, so the next command transfer
// can be taken while it waits. Configuration writes take effect at once and
// are meant to be made only while the core is idle.
module bloom_guarded_dictionary_encoder_core #(
    parameter int DICT_DEPTH  = 4096,
    parameter int FILTER_BITS = 65536
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  bgde_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bgde_pkg::result_t          out_data,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bgde_pkg::CFG_W-1:0] cfg_data
);

    bgde_pkg::ctl_t ctl;
    bgde_pkg::sts_t sts;

    bgde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    bgde_datapath #(
        .DICT_DEPTH  (DICT_DEPTH),
        .FILTER_BITS (FILTER_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule

@@ rtl/core/bgde_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bgde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bgde_hash.sv @@
// Double-hash generator: base = fmix64(w) and step = fmix64(w ^ golden) | 1.
// Uses bgde_pkg; one 32x32 multiplier is shared by every partial product.
module bgde_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] word,
    output logic        done,
    output logic [63:0] base,
    output logic [63:0] step
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] word_reg;
    logic [63:0] v_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    logic [63:0] base_reg;
    logic [63:0] step_reg;

    logic [1:0]  phase;
    logic [63:0] mix_c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] mix_sum;
    logic [63:0] mix_out;
    logic [63:0] seed_a;
    logic [63:0] seed_b;

    // cnt[1:0] walks the partial products of one 64-bit multiply, cnt[2] picks
    // the constant and cnt[3] tells the base pass from the step pass.
    assign phase   = cnt_reg[1:0];
    assign mix_c   = cnt_reg[2] ? bgde_pkg::MIX_C2 : bgde_pkg::MIX_C1;
    assign mul_a   = (phase == 2'd2) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b   = (phase == 2'd1) ? mix_c[63:32] : mix_c[31:0];
    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign mix_sum = acc_reg + {prod_reg[31:0], 32'd0};
    assign mix_out = mix_sum ^ (mix_sum >> 33);
    assign seed_a  = {32'd0, word};
    assign seed_b  = {32'd0, word_reg} ^ bgde_pkg::GOLDEN_STEP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            word_reg <= word;
            v_reg    <= seed_a ^ (seed_a >> 33);
        end
        else if (busy_reg)
        begin
            case (phase)
                2'd0:
                begin
                    prod_reg <= mul_p;
                end
                2'd1:
                begin
                    acc_reg  <= prod_reg;
                    prod_reg <= mul_p;
                end
                2'd2:
                begin
                    acc_reg  <= mix_sum;
                    prod_reg <= mul_p;
                end
                default:
                begin
                    if (!cnt_reg[2])
                    begin
                        v_reg <= mix_out;
                    end
                    else if (!cnt_reg[3])
                    begin
                        base_reg <= mix_out;
                        v_reg    <= seed_b ^ (seed_b >> 33);
                    end
                    else
                    begin
                        step_reg <= mix_out | 64'd1;
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign base = base_reg;
    assign step = step_reg;

endmodule

@@ rtl/core/bgde_mod.sv @@
// Remainder of a 64-bit value by the filter size, four quotient bits a cycle.
// No package dependencies.
module bgde_mod #(
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] rem
);

    logic          busy_reg;
    logic [3:0]    cnt_reg;
    logic          done_reg;
    logic [63:0]   dvd_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_step;
    logic [DW:0]   trial;

    // Restoring steps: the partial remainder stays below the divisor, so one
    // compare and subtract keeps it in range after each shifted-in bit.
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int j = 0; j < 4; j++)
        begin
            trial = {rem_step, dvd_reg[63-j]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_step = trial[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'd15);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 4;
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/core/bgde_datapath.sv @@
// Datapath of the dictionary encoder: registers, dictionary and filter RAMs,
// hash and remainder units. Uses bgde_pkg, bgde_ram, bgde_hash and bgde_mod.
module bgde_datapath #(
    parameter int DICT_DEPTH  = 4096,
    parameter int FILTER_BITS = 65536
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bgde_pkg::in_item_t         in_data,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bgde_pkg::CFG_W-1:0] cfg_data,
    input  bgde_pkg::ctl_t             ctl,
    output bgde_pkg::sts_t             sts,
    output bgde_pkg::result_t          out_data
);

    localparam int CNT_W        = $clog2(DICT_DEPTH + 1);
    localparam int DA_W         = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int FILTER_WORDS = (FILTER_BITS + 63) / 64;
    localparam int FW_AW        = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
    localparam int SIZE_W       = $clog2(FILTER_BITS + 1);
    localparam int PROD_W       = CNT_W + 16;

    logic [15:0]       bpe_reg;
    logic [4:0]        hc_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              ready_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [4:0]        i_reg;
    logic [FW_AW-1:0]  fclr_reg;

    bgde_pkg::cmd_e    cmd_reg;
    logic [31:0]       word_reg;
    logic [63:0]       acc_reg;
    logic [1:0]        status_reg;
    logic              pos_reg;
    logic              hit_reg;
    logic [11:0]       idx_reg;
    bgde_pkg::result_t out_reg;

    logic [PROD_W-1:0] size_prod;
    logic [PROD_W-1:0] size_ceil;
    logic [SIZE_W-1:0] size_sat;

    logic [31:0]       entry_rdata;
    logic [63:0]       filt_rdata;
    logic [63:0]       filt_wdata;
    logic [FW_AW-1:0]  filt_waddr;
    logic [FW_AW-1:0]  probe_addr;
    logic [63:0]       probe_mask;

    logic              hash_done;
    logic [63:0]       hash_base;
    logic [63:0]       hash_step;
    logic              mod_done;
    logic [SIZE_W-1:0] mod_rem;

    bgde_pkg::result_t result;

    // Filter size: ceil(count * bits_per_entry / 256), floored and saturated.
    assign size_prod = PROD_W'(count_reg) * PROD_W'(bpe_reg);
    assign size_ceil = (size_prod + PROD_W'(255)) >> 8;

    always_comb
    begin
        if (size_ceil < PROD_W'(bgde_pkg::SIZE_FLOOR))
        begin
            size_sat = SIZE_W'(bgde_pkg::SIZE_FLOOR);
        end
        else if (size_ceil > PROD_W'(FILTER_BITS))
        begin
            size_sat = SIZE_W'(FILTER_BITS);
        end
        else
        begin
            size_sat = SIZE_W'(size_ceil);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpe_reg   <= bgde_pkg::BPE_RESET;
            hc_reg    <= bgde_pkg::HC_RESET;
            count_reg <= '0;
            size_reg  <= '0;
            ready_reg <= 1'b0;
            k_reg     <= '0;
            i_reg     <= '0;
            fclr_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bgde_pkg::REG_BITS_PER_ENTRY: bpe_reg <= cfg_data;
                    bgde_pkg::REG_HASH_COUNT:     hc_reg  <= cfg_data[4:0];
                    default:                      hc_reg  <= hc_reg;
                endcase
            end
            if (ctl.clr_dict)
            begin
                count_reg <= '0;
                ready_reg <= 1'b0;
                size_reg  <= '0;
            end
            if (ctl.unbuild)
            begin
                ready_reg <= 1'b0;
                size_reg  <= '0;
            end
            if (ctl.size_calc)
            begin
                size_reg <= size_sat;
                fclr_reg <= '0;
            end
            if (ctl.fclr_step)
            begin
                fclr_reg <= fclr_reg + FW_AW'(1);
            end
            if (ctl.set_ready)
            begin
                ready_reg <= 1'b1;
            end
            if (ctl.entry_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.k_clear)
            begin
                k_reg <= '0;
            end
            else if (ctl.k_inc)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            if (ctl.probe_init)
            begin
                i_reg <= '0;
            end
            else if (ctl.probe_next)
            begin
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg    <= in_data.command;
            word_reg   <= in_data.data_word;
            status_reg <= bgde_pkg::STATUS_OK;
            pos_reg    <= 1'b0;
            hit_reg    <= 1'b0;
            idx_reg    <= '0;
        end
        if (ctl.entry_write)
        begin
            idx_reg <= 12'(count_reg);
        end
        if (ctl.set_found)
        begin
            hit_reg <= 1'b1;
            idx_reg <= 12'(k_reg);
        end
        if (ctl.set_full)
        begin
            status_reg <= bgde_pkg::STATUS_FULL;
        end
        if (ctl.set_not_built)
        begin
            status_reg <= bgde_pkg::STATUS_NOT_BUILT;
        end
        if (ctl.set_pos)
        begin
            pos_reg <= 1'b1;
        end
        if (ctl.probe_init)
        begin
            acc_reg <= hash_base;
        end
        else if (ctl.probe_next)
        begin
            acc_reg <= acc_reg + hash_step;
        end
        if (ctl.out_load)
        begin
            out_reg <= result;
        end
    end

    bgde_ram #(
        .WIDTH (32),
        .DEPTH (DICT_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ctl.entry_write),
        .waddr (count_reg[DA_W-1:0]),
        .wdata (word_reg),
        .raddr (k_reg[DA_W-1:0]),
        .rdata (entry_rdata)
    );

    assign probe_addr = FW_AW'(mod_rem >> 6);
    assign probe_mask = 64'd1 << mod_rem[5:0];
    assign filt_waddr = ctl.fclr_step ? fclr_reg : probe_addr;
    assign filt_wdata = ctl.fclr_step ? 64'd0 : (filt_rdata | probe_mask);

    bgde_ram #(
        .WIDTH (64),
        .DEPTH (FILTER_WORDS)
    ) u_filter_ram (
        .clk   (clk),
        .we    (ctl.fclr_step || ctl.filt_set),
        .waddr (filt_waddr),
        .wdata (filt_wdata),
        .raddr (probe_addr),
        .rdata (filt_rdata)
    );

    bgde_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.hash_start),
        .word  (ctl.hash_src_entry ? entry_rdata : word_reg),
        .done  (hash_done),
        .base  (hash_base),
        .step  (hash_step)
    );

    bgde_mod #(
        .DW (SIZE_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.mod_start),
        .dividend (acc_reg),
        .divisor  (size_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        result.status          = status_reg;
        result.filter_positive = pos_reg;
        result.exact_hit       = hit_reg;
        result.entry_index     = idx_reg;
        result.miss_word       = ((cmd_reg == bgde_pkg::CMD_ENCODE) && !hit_reg) ? word_reg
                                                                                  : 32'd0;
        result.entry_count     = 13'(count_reg);
        result.filter_size     = 17'(size_reg);
        if (32'(count_reg) <= 32'd256)
        begin
            result.index_bytes = 3'd1;
        end
        else if (32'(count_reg) <= 32'd65536)
        begin
            result.index_bytes = 3'd2;
        end
        else
        begin
            result.index_bytes = 3'd4;
        end
    end

    assign sts.cmd        = cmd_reg;
    assign sts.k_lt_count = (k_reg < count_reg);
    assign sts.found_eq   = (entry_rdata == word_reg);
    assign sts.full       = (32'(count_reg) >= 32'(DICT_DEPTH));
    assign sts.ready_ok   = ready_reg && (size_reg != '0);
    assign sts.fclr_last  = (32'(fclr_reg) == 32'(FILTER_WORDS - 1));
    assign sts.hash_done  = hash_done;
    assign sts.mod_done   = mod_done;
    assign sts.i_lt_hc    = (i_reg < hc_reg);
    assign sts.bit_set    = |(filt_rdata & probe_mask);

    assign out_data = out_reg;

endmodule

@@ rtl/core/bgde_ctrl.sv @@
// Controller state machine of the dictionary encoder; sequences the datapath.
// Uses bgde_pkg for the command and status structs.
module bgde_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  bgde_pkg::sts_t sts,
    output bgde_pkg::ctl_t ctl
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b000000000001,
        ST_DISPATCH = 12'b000000000010,
        ST_SR_RD    = 12'b000000000100,
        ST_SR_CMP   = 12'b000000001000,
        ST_BCLR     = 12'b000000010000,
        ST_BNEXT    = 12'b000000100000,
        ST_BHASH    = 12'b000001000000,
        ST_HWAIT    = 12'b000010000000,
        ST_PCHK     = 12'b000100000000,
        ST_MWAIT    = 12'b001000000000,
        ST_PRD      = 12'b010000000000,
        ST_PUSH     = 12'b100000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.cmd)
                    bgde_pkg::CMD_CLEAR:
                    begin
                        ctl.clr_dict = 1'b1;
                        state_next   = ST_PUSH;
                    end
                    bgde_pkg::CMD_ADD:
                    begin
                        ctl.unbuild = 1'b1;
                        ctl.k_clear = 1'b1;
                        state_next  = ST_SR_RD;
                    end
                    bgde_pkg::CMD_BUILD:
                    begin
                        ctl.size_calc = 1'b1;
                        state_next    = ST_BCLR;
                    end
                    default:
                    begin
                        if (!sts.ready_ok)
                        begin
                            ctl.set_not_built = 1'b1;
                            state_next        = ST_PUSH;
                        end
                        else
                        begin
                            ctl.hash_start = 1'b1;
                            state_next     = ST_HWAIT;
                        end
                    end
                endcase
            end
            // The entry at k is read this cycle and compared in the next one.
            ST_SR_RD:
            begin
                if (!sts.k_lt_count)
                begin
                    if (sts.cmd == bgde_pkg::CMD_ADD)
                    begin
                        if (sts.full)
                        begin
                            ctl.set_full = 1'b1;
                        end
                        else
                        begin
                            ctl.entry_write = 1'b1;
                        end
                    end
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = ST_SR_CMP;
                end
            end
            ST_SR_CMP:
            begin
                if (sts.found_eq)
                begin
                    ctl.set_found = 1'b1;
                    state_next    = ST_PUSH;
                end
                else
                begin
                    ctl.k_inc  = 1'b1;
                    state_next = ST_SR_RD;
                end
            end
            ST_BCLR:
            begin
                ctl.fclr_step = 1'b1;
                if (sts.fclr_last)
                begin
                    ctl.k_clear = 1'b1;
                    state_next  = ST_BNEXT;
                end
            end
            ST_BNEXT:
            begin
                if (!sts.k_lt_count)
                begin
                    ctl.set_ready = 1'b1;
                    state_next    = ST_PUSH;
                end
                else
                begin
                    state_next = ST_BHASH;
                end
            end
            ST_BHASH:
            begin
                ctl.hash_start     = 1'b1;
                ctl.hash_src_entry = 1'b1;
                state_next         = ST_HWAIT;
            end
            ST_HWAIT:
            begin
                if (sts.hash_done)
                begin
                    ctl.probe_init = 1'b1;
                    state_next     = ST_PCHK;
                end
            end
            ST_PCHK:
            begin
                if (!sts.i_lt_hc)
                begin
                    if (sts.cmd == bgde_pkg::CMD_BUILD)
                    begin
                        ctl.k_inc  = 1'b1;
                        state_next = ST_BNEXT;
                    end
                    else
                    begin
                        // Every probed bit was set: confirm in the dictionary.
                        ctl.set_pos = 1'b1;
                        ctl.k_clear = 1'b1;
                        state_next  = ST_SR_RD;
                    end
                end
                else
                begin
                    ctl.mod_start = 1'b1;
                    state_next    = ST_MWAIT;
                end
            end
            ST_MWAIT:
            begin
                if (sts.mod_done)
                begin
                    state_next = ST_PRD;
                end
            end
            ST_PRD:
            begin
                if (sts.cmd == bgde_pkg::CMD_BUILD)
                begin
                    ctl.filt_set   = 1'b1;
                    ctl.probe_next = 1'b1;
                    state_next     = ST_PCHK;
                end
                else if (sts.bit_set)
                begin
                    ctl.probe_next = 1'b1;
                    state_next     = ST_PCHK;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/core/bgde_checker.sv @@
// Port-level checker for the dictionary encoder core, bound to its top level.
// Uses bgde_pkg and the core's assertion macro header.
`include "bloom_guarded_dictionary_encoder_core_macros.svh"

module bgde_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input bgde_pkg::result_t out_data
);

    `BGDE_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `BGDE_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall |=> in_stall, "second command taken while busy")
    `BGDE_ASSERT(a_full_clean, clk, rst_n, out_valid && (out_data.status == bgde_pkg::STATUS_FULL) |-> !out_data.exact_hit && (out_data.entry_index == 12'd0), "full result carries an index")
    `BGDE_ASSERT(a_positive_built, clk, rst_n, out_valid && out_data.filter_positive |-> (out_data.status == bgde_pkg::STATUS_OK) && (out_data.filter_size != 17'd0), "positive from an unbuilt filter")
    `BGDE_ASSERT(a_index_bytes, clk, rst_n, out_valid |-> ((out_data.entry_count <= 13'd256) == (out_data.index_bytes == 3'd1)), "index width disagrees with count")

endmodule

bind bloom_guarded_dictionary_encoder_core bgde_checker u_bgde_checker (.*);
